### hw/rtl/refm_pkg.sv
package refm_pkg;

  localparam int TIME_W  = 64;
  localparam int GAP_W   = 32;
  localparam int WAVE_W  = 16;
  localparam int HZ_W    = 20;
  localparam int DIV_CNT_W = $clog2(HZ_W);

  // Numerator of the frequency computation: one second in microseconds.
  localparam logic [HZ_W-1:0] HZ_NUM = HZ_W'(1000000);

  localparam logic [WAVE_W-1:0] MAX_WAVES_RST = WAVE_W'(2);

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_EDGE  = 2'd1,
    REQ_STOP  = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DIV  = 1'b1
  } state_e;

  typedef struct packed {
    logic             resync;
    logic             running;
    logic [HZ_W-1:0]  hz;
    logic             hz_valid;
  } res_t;

  // Capture status handed from the interval tracker to the control logic.
  typedef struct packed {
    logic [GAP_W-1:0] max_gap;
    logic             enough;
  } cap_stat_t;

endpackage

### hw/rtl/refm_cap.sv
module refm_cap #(
  parameter int CAPTURE_DEPTH = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          edge_i,
  input  logic [refm_pkg::TIME_W-1:0]   stamp_i,
  output refm_pkg::cap_stat_t           stat_o
);

  localparam int CNT_W = $clog2(CAPTURE_DEPTH + 1);

  logic                         flag_q, flag_d;
  logic [CNT_W-1:0]             cnt_q, cnt_d;
  logic [refm_pkg::GAP_W-1:0]   prev_q, prev_d;
  logic [refm_pkg::GAP_W-1:0]   max_q, max_d;
  logic [refm_pkg::GAP_W-1:0]   gap;

  // Only the low word of the stamps matters: the interval wraps modulo 2^32.
  assign gap = stamp_i[refm_pkg::GAP_W-1:0] - prev_q;

  always_comb begin
    flag_d = flag_q;
    cnt_d  = cnt_q;
    prev_d = prev_q;
    max_d  = max_q;
    if (start_i) begin
      flag_d = 1'b1;
      cnt_d  = '0;
      max_d  = '0;
    end else if (edge_i && flag_q) begin
      if ((cnt_q != '0) && (gap > max_q)) begin
        max_d = gap;
      end
      prev_d = stamp_i[refm_pkg::GAP_W-1:0];
      cnt_d  = cnt_q + CNT_W'(1);
      if (cnt_q >= CNT_W'(CAPTURE_DEPTH - 1)) begin
        flag_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
      cnt_q  <= '0;
      max_q  <= '0;
    end else begin
      flag_q <= flag_d;
      cnt_q  <= cnt_d;
      max_q  <= max_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
  end

  assign stat_o.max_gap = max_q;
  assign stat_o.enough  = (cnt_q > CNT_W'(1));

endmodule

### hw/rtl/refm_div.sv
module refm_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [refm_pkg::GAP_W-1:0]   divisor_i,
  output logic                         done_o,
  output logic [refm_pkg::HZ_W-1:0]    quot_o
);

  logic                                busy_q, busy_d;
  logic                                done_q, done_d;
  logic [refm_pkg::DIV_CNT_W-1:0]      cnt_q, cnt_d;
  logic [refm_pkg::GAP_W-1:0]          den_q, den_d;
  logic [refm_pkg::GAP_W-1:0]          rem_q, rem_d;
  logic [refm_pkg::HZ_W-1:0]           nq_q, nq_d;
  logic [refm_pkg::GAP_W:0]            trial;
  logic [refm_pkg::GAP_W:0]            diff;
  logic                                qbit;

  // One quotient bit per cycle: the numerator shifts out at the top while
  // the quotient shifts in at the bottom of the same register.
  assign trial = {rem_q, nq_q[refm_pkg::HZ_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign qbit  = (trial >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    den_d  = den_q;
    rem_d  = rem_q;
    nq_d   = nq_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      den_d  = divisor_i;
      rem_d  = '0;
      nq_d   = refm_pkg::HZ_NUM;
    end else if (busy_q) begin
      rem_d = qbit ? diff[refm_pkg::GAP_W-1:0] : trial[refm_pkg::GAP_W-1:0];
      nq_d  = {nq_q[refm_pkg::HZ_W-2:0], qbit};
      cnt_d = cnt_q + refm_pkg::DIV_CNT_W'(1);
      if (cnt_q == refm_pkg::DIV_CNT_W'(refm_pkg::HZ_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q <= den_d;
    rem_q <= rem_d;
    nq_q  <= nq_d;
  end

  assign done_o = done_q;
  assign quot_o = nq_q;

endmodule

### hw/rtl/resonant_edge_resync_and_freq_meter_core.sv
// Start, edge and unused items finish in the accepting cycle; the result is registered
//   into the result buffer. A stop with a usable interval waits for the bit-serial
//   divider, which produces one quotient bit per cycle over 20 bits.
// Throughput: one item per cycle for start and edge items while the skid entry is free;
//   a stop that starts the divider blocks new items until the quotient is buffered.
// Reset (rst_ni, async, active low): drive stopped, counts cleared, max_waves = 2.
module resonant_edge_resync_and_freq_meter_core #(
  parameter int CAPTURE_DEPTH = 10
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [refm_pkg::WAVE_W-1:0]        max_waves_i,
  // input transactions
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         req_type_i,
  input  logic [refm_pkg::TIME_W-1:0]        time_us_i,
  // result transactions
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               resync_o,
  output logic                               running_o,
  output logic [refm_pkg::HZ_W-1:0]          measured_hz_o,
  output logic                               hz_valid_o
);

  // Control state
  refm_pkg::state_e                  state_q, state_d;
  logic                              run_q, run_d;
  logic [refm_pkg::WAVE_W-1:0]       edge_cnt_q, edge_cnt_d;
  logic [refm_pkg::WAVE_W-1:0]       max_waves_q;
  logic [refm_pkg::WAVE_W-1:0]       edge_inc;

  // Result buffer: head register plus one skid entry
  logic                              out_v_q, out_v_d;
  logic                              skid_v_q, skid_v_d;
  refm_pkg::res_t                    out_q, out_d;
  refm_pkg::res_t                    skid_q, skid_d;
  refm_pkg::res_t                    res;
  logic                              push;
  logic                              pop;

  logic                              accept;
  refm_pkg::req_e                    req;
  logic                              cap_start;
  logic                              cap_edge;
  refm_pkg::cap_stat_t               cap_stat;
  logic                              div_start;
  logic                              div_done;
  logic [refm_pkg::HZ_W-1:0]         div_quot;

  assign req        = refm_pkg::req_e'(req_type_i);
  assign accept     = in_valid_i && in_ready_o;
  // Take new work only when idle and the skid entry can absorb a result.
  assign in_ready_o = (state_q == refm_pkg::ST_IDLE) && !skid_v_q;
  assign cfg_ready_o = 1'b1;

  assign edge_inc  = edge_cnt_q + refm_pkg::WAVE_W'(1);
  assign cap_start = accept && (req == refm_pkg::REQ_START);
  assign cap_edge  = accept && (req == refm_pkg::REQ_EDGE) && run_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_waves_q <= refm_pkg::MAX_WAVES_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_waves_q <= max_waves_i;
    end
  end

  // Next state, run tracking and result formation.
  always_comb begin
    state_d    = state_q;
    run_d      = run_q;
    edge_cnt_d = edge_cnt_q;
    div_start  = 1'b0;
    push       = 1'b0;
    res        = '0;
    case (state_q)
      refm_pkg::ST_IDLE: begin
        if (accept) begin
          case (req)
            refm_pkg::REQ_START: begin
              run_d       = 1'b1;
              edge_cnt_d  = '0;
              push        = 1'b1;
              res.running = 1'b1;
            end
            refm_pkg::REQ_EDGE: begin
              if (run_q) begin
                // Count the wave; on reaching the limit, fire resync and wrap.
                if (edge_inc >= max_waves_q) begin
                  res.resync = 1'b1;
                  edge_cnt_d = '0;
                end else begin
                  edge_cnt_d = edge_inc;
                end
              end
              push        = 1'b1;
              res.running = run_q;
            end
            refm_pkg::REQ_STOP: begin
              run_d = 1'b0;
              if (cap_stat.enough && (cap_stat.max_gap != '0)) begin
                // Hand the interval to the divider and wait for the quotient.
                div_start = 1'b1;
                state_d   = refm_pkg::ST_DIV;
              end else begin
                push         = 1'b1;
                res.hz_valid = 1'b1;
              end
            end
            default: begin
              push        = 1'b1;
              res.running = run_q;
            end
          endcase
        end
      end
      refm_pkg::ST_DIV: begin
        if (div_done) begin
          push         = 1'b1;
          res.hz       = div_quot;
          res.hz_valid = 1'b1;
          state_d      = refm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = refm_pkg::ST_IDLE;
      end
    endcase
  end

  // Result buffer: advance the skid entry on a pop, then place the new result.
  assign pop = out_v_q && out_ready_i;

  always_comb begin
    out_v_d  = out_v_q;
    out_d    = out_q;
    skid_v_d = skid_v_q;
    skid_d   = skid_q;
    if (pop) begin
      out_v_d  = skid_v_q;
      out_d    = skid_q;
      skid_v_d = 1'b0;
    end
    if (push) begin
      if (!out_v_d) begin
        out_v_d = 1'b1;
        out_d   = res;
      end else begin
        skid_v_d = 1'b1;
        skid_d   = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= refm_pkg::ST_IDLE;
      run_q      <= 1'b0;
      edge_cnt_q <= '0;
      out_v_q    <= 1'b0;
      skid_v_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      run_q      <= run_d;
      edge_cnt_q <= edge_cnt_d;
      out_v_q    <= out_v_d;
      skid_v_q   <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  refm_cap #(
    .CAPTURE_DEPTH (CAPTURE_DEPTH)
  ) u_cap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cap_start),
    .edge_i  (cap_edge),
    .stamp_i (time_us_i),
    .stat_o  (cap_stat)
  );

  refm_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (cap_stat.max_gap),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  assign out_valid_o   = out_v_q;
  assign resync_o      = out_q.resync;
  assign running_o     = out_q.running;
  assign measured_hz_o = out_q.hz;
  assign hz_valid_o    = out_q.hz_valid;

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == refm_pkg::ST_IDLE))
    else $error("input ready outside idle");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == refm_pkg::ST_DIV))
    else $error("divider finished while not waiting on it");

  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid entry holds a result while head is empty");

  a_stop_not_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.hz_valid) |-> (!out_q.running && !out_q.resync))
    else $error("frequency report claims running or resync");

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> (state_q == refm_pkg::ST_DIV))
    else $error("divider started without entering wait state");

endmodule

### test/tb_resonant_edge_resync_and_freq_meter_core.sv
`timescale 1ns / 1ps

module tb_resonant_edge_resync_and_freq_meter_core;

  localparam int          CAPTURES    = 10;
  localparam int unsigned US_PER_S    = 1000000;
  localparam int          CYCLE_LIMIT = 500000;
  localparam int          HOLD_CYCLES = 400;

  typedef struct {
    refm_pkg::req_e              kind;
    logic [refm_pkg::TIME_W-1:0] stamp;
  } sense_item_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [refm_pkg::WAVE_W-1:0] max_waves_i = '0;
  logic                        in_valid_i = 1'b0;
  logic                        in_ready_o;
  logic [1:0]                  req_type_i = '0;
  logic [refm_pkg::TIME_W-1:0] time_us_i = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic                        resync_o;
  logic                        running_o;
  logic [refm_pkg::HZ_W-1:0]   measured_hz_o;
  logic                        hz_valid_o;

  // Items waiting to be offered, and meter results waiting to come back.
  sense_item_t     sense_items[$];
  refm_pkg::res_t  meter_reports[$];

  // Shadow of the block's state, advanced once per accepted transaction.
  logic                        drive_on;
  logic                        capturing;
  logic [refm_pkg::WAVE_W-1:0] wave_cnt;
  logic [refm_pkg::WAVE_W-1:0] wave_limit;
  int                          cap_cnt;
  logic [refm_pkg::TIME_W-1:0] last_stamp;
  logic [refm_pkg::GAP_W-1:0]  widest_gap;

  int   idle_pct = 33;
  logic hold_req = 1'b0;
  logic hold_used;
  int   hold_left;
  int   bad_results = 0;
  int   queued_items = 0;
  int   cycle_cnt = 0;

  resonant_edge_resync_and_freq_meter_core #(
    .CAPTURE_DEPTH(CAPTURES)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .max_waves_i   (max_waves_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .time_us_i     (time_us_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .resync_o      (resync_o),
    .running_o     (running_o),
    .measured_hz_o (measured_hz_o),
    .hz_valid_o    (hz_valid_o)
  );

  always #2 clk_i = ~clk_i;

  // Advance the shadow meter by one transaction and return the result it owes.
  function automatic refm_pkg::res_t advance_meter(
    input refm_pkg::req_e              kind,
    input logic [refm_pkg::TIME_W-1:0] stamp
  );
    refm_pkg::res_t             r;
    logic [refm_pkg::GAP_W-1:0] gap;
    r = '0;
    case (kind)
      refm_pkg::REQ_START: begin
        // A start while running simply restarts: clear counts, rearm capture.
        drive_on   = 1'b1;
        wave_cnt   = '0;
        capturing  = 1'b1;
        cap_cnt    = 0;
        widest_gap = '0;
      end
      refm_pkg::REQ_EDGE: begin
        // Edges while stopped change nothing.
        if (drive_on) begin
          wave_cnt = wave_cnt + 1'b1;
          if (wave_cnt >= wave_limit) begin
            r.resync = 1'b1;
            wave_cnt = '0;
          end
          if (capturing) begin
            // Truncate the interval to 32 bits, so stamps going backwards wrap.
            if (cap_cnt > 0) begin
              gap = stamp[refm_pkg::GAP_W-1:0] - last_stamp[refm_pkg::GAP_W-1:0];
              if (gap > widest_gap) widest_gap = gap;
            end
            last_stamp = stamp;
            cap_cnt++;
            if (cap_cnt >= CAPTURES) capturing = 1'b0;
          end
        end
      end
      refm_pkg::REQ_STOP: begin
        // Report even when already stopped; too few captures or a zero gap give 0 Hz.
        drive_on   = 1'b0;
        r.hz_valid = 1'b1;
        if (cap_cnt > 1 && widest_gap != '0)
          r.hz = refm_pkg::HZ_W'(refm_pkg::GAP_W'(US_PER_S) / widest_gap);
      end
      default: ;
    endcase
    r.running = drive_on;
    return r;
  endfunction

  // Driver: retire the accepted transaction, then offer the next one or idle.
  always @(posedge clk_i or negedge rst_ni) begin
    sense_item_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o)
        meter_reports.push_back(advance_meter(refm_pkg::req_e'(req_type_i), time_us_i));
      if (!in_valid_i || in_ready_o) begin
        if (sense_items.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          nxt = sense_items.pop_front();
          in_valid_i <= 1'b1;
          req_type_i <= nxt.kind;
          time_us_i  <= nxt.stamp;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, armed once by the stimulus, so the block backs up.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end
  end

  // Monitor: check each accepted result against the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    refm_pkg::res_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (meter_reports.size() == 0) begin
          if (bad_results < 10)
            $display("unexpected result: resync %0b running %0b hz %0d hz_valid %0b",
                     resync_o, running_o, measured_hz_o, hz_valid_o);
          bad_results++;
        end else begin
          want = meter_reports.pop_front();
          if (resync_o !== want.resync || running_o !== want.running ||
              measured_hz_o !== want.hz || hz_valid_o !== want.hz_valid) begin
            if (bad_results < 10)
              $display({"result mismatch: expected resync %0b running %0b hz %0d hz_valid %0b,",
                        " got resync %0b running %0b hz %0d hz_valid %0b"},
                       want.resync, want.running, want.hz, want.hz_valid,
                       resync_o, running_o, measured_hz_o, hz_valid_o);
            bad_results++;
          end
        end
      end
      out_ready_i <= (hold_left == 0) && ($urandom_range(0, 99) >= idle_pct);
    end
  end

  // Watchdog: drop the run if it never drains.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic push_item(input refm_pkg::req_e kind,
                           input logic [refm_pkg::TIME_W-1:0] stamp);
    sense_item_t it;
    it.kind  = kind;
    it.stamp = stamp;
    sense_items.push_back(it);
    queued_items++;
  endtask

  // Hold until every item is accepted and every result is back.
  task automatic wait_drained();
    while (sense_items.size() != 0 || in_valid_i || meter_reports.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_wave_limit(input logic [refm_pkg::WAVE_W-1:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    max_waves_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    wave_limit = v;
  endtask

  // Mostly well-formed runs: start, a burst of edges with plausible spacing, stop.
  // Mix in stray items of any kind with arbitrary stamps.
  task automatic queue_random(input int n);
    int                          goal;
    int                          len;
    int                          pick;
    logic [refm_pkg::TIME_W-1:0] stamp;
    goal = queued_items + n;
    while (queued_items < goal) begin
      if ($urandom_range(0, 99) < 80) begin
        len   = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 14);
        stamp = {$urandom, $urandom};
        push_item(refm_pkg::REQ_START, {$urandom, $urandom});
        repeat (len) begin
          pick = $urandom_range(0, 99);
          if (pick < 8)       stamp = stamp;
          else if (pick < 13) stamp = stamp + {32'd0, $urandom};
          else if (pick < 16) stamp = {$urandom, $urandom};
          else                stamp = stamp + $urandom_range(1, 5000);
          push_item(refm_pkg::REQ_EDGE, stamp);
        end
        if ($urandom_range(0, 99) < 85) push_item(refm_pkg::REQ_STOP, {$urandom, $urandom});
      end else begin
        push_item(refm_pkg::req_e'($urandom_range(0, 3)), {$urandom, $urandom});
      end
    end
  endtask

  initial begin
    logic [refm_pkg::WAVE_W-1:0] limits[6];
    logic [refm_pkg::TIME_W-1:0] stamp;
    limits = '{16'd0, 16'd1, 16'hFFFF, 16'd3,
               refm_pkg::WAVE_W'($urandom_range(2, 12)), 16'd2};

    drive_on   = 1'b0;
    capturing  = 1'b0;
    wave_cnt   = '0;
    wave_limit = refm_pkg::MAX_WAVES_RST;
    cap_cnt    = 0;
    last_stamp = '0;
    widest_gap = '0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, reset wave limit of two.
    push_item(refm_pkg::REQ_STOP, '0);         // report with nothing captured
    push_item(refm_pkg::REQ_EDGE, 64'd5);      // edge while stopped
    push_item(refm_pkg::REQ_NONE, '1);         // unused selector
    push_item(refm_pkg::REQ_START, '0);
    push_item(refm_pkg::REQ_EDGE, 64'd1000);
    push_item(refm_pkg::REQ_EDGE, 64'd1250);
    push_item(refm_pkg::REQ_EDGE, 64'd1250);   // zero interval
    push_item(refm_pkg::REQ_START, '1);        // restart while running
    push_item(refm_pkg::REQ_EDGE, '1);
    push_item(refm_pkg::REQ_EDGE, '0);         // stamp wraps, interval of one
    push_item(refm_pkg::REQ_STOP, '0);
    push_item(refm_pkg::REQ_STOP, '0);         // stop while stopped reports last run
    push_item(refm_pkg::REQ_START, '0);
    push_item(refm_pkg::REQ_EDGE, 64'd7);
    push_item(refm_pkg::REQ_STOP, '0);         // single capture
    // Run past the capture depth; the late huge gap must not count.
    push_item(refm_pkg::REQ_START, '0);
    stamp = 64'hA5A5_5A5A_0000_0000;
    for (int i = 0; i < 11; i++) begin
      stamp = (i == 10) ? stamp + 64'hFFFF_0000 : stamp + 40 + i;
      push_item(refm_pkg::REQ_EDGE, stamp);
    end
    push_item(refm_pkg::REQ_STOP, '0);
    wait_drained();

    foreach (limits[i]) begin
      write_wave_limit(limits[i]);
      // One phase with no idling at all; one with the long receiver hold-off.
      idle_pct <= (i == 1) ? 0 : 33;
      hold_req <= (i == 3);
      queue_random(205);
      wait_drained();
    end

    repeat (30) @(posedge clk_i);
    if (bad_results == 0 && meter_reports.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
